FILE: rtl/iss_pkg.sv
// Package for the indexed sequence store.
// Holds the sizes, command and status codes and the broadcast op struct.
// No dependencies.
package iss_pkg;

    localparam int CAPACITY = 16;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_AT    = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_BACK  = 3'd2,
        CMD_REM_AT    = 3'd3,
        CMD_REM_FRONT = 3'd4,
        CMD_REM_BACK  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] data;
    } t_op;

endpackage

FILE: rtl/iss_req_if.sv
// Request channel: valid/ready with cmd, position and data_in.
// Depends on iss_pkg.
interface iss_req_if import iss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, cmd, position, data_in, input ready);
    modport sink   (input valid, cmd, position, data_in, output ready);
endinterface

FILE: rtl/iss_rsp_if.sv
// Response channel: valid/ready with data_out, status and length.
// Depends on iss_pkg.
interface iss_rsp_if import iss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;

    modport source (output valid, data_out, status, length, input ready);
    modport sink   (input valid, data_out, status, length, output ready);
endinterface

FILE: rtl/indexed_sequence_store.sv
// Top level of the indexed sequence store: control plus a chain of cells.
// Depends on iss_pkg, iss_req_if, iss_rsp_if, iss_cell, iss_ctrl.
//
//   channel  dir  payload                      transfer when
//   i_req    in   cmd, position, data_in       valid && ready
//   o_rsp    out  data_out, status, length     valid && ready
//
// On the edge that ends the accept cycle the whole cell chain shifts and
// the response is loaded into the output register. One request per cycle
// while o_rsp is taken.
// Synchronous active-low reset clears the entry count and the output valid.
// i_req.ready drops only while a response is held and o_rsp.ready is low.
module indexed_sequence_store import iss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iss_req_if.sink   i_req,
    iss_rsp_if.source o_rsp
);

    t_op                      op;
    logic signed [DATA_W-1:0] vals [CAPACITY];
    logic signed [DATA_W-1:0] hits [CAPACITY];
    logic signed [DATA_W-1:0] rd_data;

    iss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_rd_data (rd_data),
        .o_op      (op)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid
            assign left = vals[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = vals[g];
        end else begin : g_inner
            assign right = vals[g+1];
        end
        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (POS_W'(g)),
            .i_op    (op),
            .i_left  (left),
            .i_right (right),
            .o_val   (vals[g]),
            .o_hit   (hits[g])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | hits[k];
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.data_out == '0))
        else $error("error response carries nonzero data");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.length <= LEN_W'(CAPACITY)))
        else $error("length above capacity");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_EMPTY)) |-> (o_rsp.length == '0))
        else $error("empty status with nonzero length");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_FULL))
            |-> (o_rsp.length == LEN_W'(CAPACITY)))
        else $error("full status with length below capacity");

endmodule

FILE: rtl/iss_cell.sv
// One chain cell: holds one entry, takes the left neighbor on an insert
// below it, the op data at it, the right neighbor on a remove at/below it.
// Depends on iss_pkg.
module iss_cell import iss_pkg::*; (
    input  logic                     i_clk,
    input  logic [POS_W-1:0]         i_idx,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_val,
    output logic signed [DATA_W-1:0] o_hit
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_op.ins) begin
            if (i_idx > i_op.pos) begin
                n_val = i_left;
            end else if (i_idx == i_op.pos) begin
                n_val = i_op.data;
            end
        end
        if (i_op.rem && (i_idx >= i_op.pos)) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_hit = (i_idx == i_op.pos) ? r_val : '0;

endmodule

FILE: rtl/iss_ctrl.sv
// Request decode, length counter, status checks and response register.
// Depends on iss_pkg, iss_req_if, iss_rsp_if.
module iss_ctrl import iss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    iss_req_if.sink                  i_req,
    iss_rsp_if.source                o_rsp,
    input  logic signed [DATA_W-1:0] i_rd_data,
    output t_op                      o_op
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_vld;
    logic signed [DATA_W-1:0] r_data;
    t_status                  r_status;
    logic [LEN_W-1:0]         r_len;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [POS_W-1:0]         cnt_pos;
    logic                     do_ins;
    logic                     do_rem;
    logic [POS_W-1:0]         sel_pos;
    t_status                  st;

    assign i_req.ready = !r_vld || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign empty       = (r_count == '0);
    assign cnt_pos     = POS_W'(r_count);

    always_comb begin
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        sel_pos = '0;
        st      = ST_OK;
        case (t_cmd'(i_req.cmd))
            CMD_INS_AT: begin
                if (full) begin
                    st = ST_FULL;
                end else if (i_req.position > cnt_pos) begin
                    st = ST_RANGE;
                end else begin
                    do_ins  = 1'b1;
                    sel_pos = i_req.position;
                end
            end
            CMD_INS_FRONT: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_INS_BACK: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    sel_pos = cnt_pos;
                end
            end
            CMD_REM_AT: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else if (i_req.position >= cnt_pos) begin
                    st = ST_RANGE;
                end else begin
                    do_rem  = 1'b1;
                    sel_pos = i_req.position;
                end
            end
            CMD_REM_FRONT: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                end
            end
            CMD_REM_BACK: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    do_rem  = 1'b1;
                    sel_pos = cnt_pos - POS_W'(1);
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    always_comb begin
        o_op.ins  = accept && do_ins;
        o_op.rem  = accept && do_rem;
        o_op.pos  = sel_pos;
        o_op.data = i_req.data_in;
    end

    always_comb begin
        n_count = r_count;
        if (o_op.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (o_op.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data   <= do_rem ? i_rd_data : '0;
            r_status <= st;
            r_len    <= LEN_W'(n_count);
        end
    end

    assign o_rsp.valid    = r_vld;
    assign o_rsp.data_out = r_data;
    assign o_rsp.status   = r_status;
    assign o_rsp.length   = r_len;

endmodule
